### src/svn_pkg.sv
// Shared types and constants for the smooth vertex normals unit.
package svn_pkg;

  localparam int unsigned MaxVerticesDef = 1024;
  localparam int unsigned AccBitsDef     = 48;
  localparam int unsigned IdxW           = 10;
  localparam int unsigned PosW           = 16;
  localparam int unsigned NrmW           = 16;
  localparam int unsigned InW            = 80;
  localparam int unsigned OutW           = 64;
  localparam int unsigned CntW           = 6;

  localparam logic [1:0] ACT_STORE = 2'd0;
  localparam logic [1:0] ACT_TRI   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic [NrmW-1:0] ONE_Q14 = 16'd16384;

  typedef struct packed {
    logic            accept;
    logic            store_wr;
    logic            pos_rd;
    logic [1:0]      sel;
    logic            pos_lat;
    logic [1:0]      lat_sel;
    logic            diff;
    logic            mac;
    logic            acc_rd;
    logic            acc_add;
    logic            q_rd;
    logic            q_lat;
    logic            clr_wr;
    logic            shift;
    logic            sq;
    logic            sqrt;
    logic            div;
    logic            out_load;
    logic [CntW-1:0] cnt;
  } svn_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       a_ok;
    logic       tri_ok;
    logic       face_zero;
    logic       acc_zero;
    logic       need_shift;
    logic       out_free;
  } svn_status_t;

endpackage

### src/svn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module svn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### src/svn_ctrl.sv
// Controller state machine for the smooth vertex normals unit.
module svn_ctrl #(
  parameter int unsigned MAX_VERTICES = svn_pkg::MaxVerticesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  svn_pkg::svn_status_t            status_i,
  output svn_pkg::svn_cmd_t               cmd_o,
  output logic [$clog2(MAX_VERTICES)-1:0] clr_addr_o
);
  import svn_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam logic [AW-1:0] LastAddr = AW'(MAX_VERTICES - 1);

  typedef enum logic [15:0] {
    S_CLEAR  = 16'h0001,
    S_IDLE   = 16'h0002,
    S_TRI_RD = 16'h0004,
    S_DIFF   = 16'h0008,
    S_MAC    = 16'h0010,
    S_CHK    = 16'h0020,
    S_ACC_RD = 16'h0040,
    S_ACC_WR = 16'h0080,
    S_Q_RD   = 16'h0100,
    S_Q_LAT  = 16'h0200,
    S_Q_CHK  = 16'h0400,
    S_SHIFT  = 16'h0800,
    S_SQ     = 16'h1000,
    S_SQRT   = 16'h2000,
    S_DIV    = 16'h4000,
    S_OUT    = 16'h8000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AW-1:0]   clr_q, clr_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    clr_d      = clr_q;
    cmd_o      = '0;
    cmd_o.cnt  = cnt_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        clr_d = clr_q + AW'(1);
        if (clr_q == LastAddr) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cnt_d = '0;
          if (status_i.action == ACT_STORE) begin
            cmd_o.store_wr = status_i.a_ok;
          end else if (status_i.action == ACT_TRI) begin
            if (status_i.tri_ok) begin
              state_d = S_TRI_RD;
            end
          end else if (status_i.action == ACT_QUERY) begin
            state_d = status_i.a_ok ? S_Q_RD : S_OUT;
          end
        end
      end
      S_TRI_RD: begin
        cmd_o.pos_rd  = (cnt_q != CntW'(3));
        cmd_o.sel     = cnt_q[1:0];
        cmd_o.pos_lat = (cnt_q != '0);
        cmd_o.lat_sel = cnt_q[1:0] - 2'd1;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(3)) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        cnt_d   = '0;
        state_d = S_MAC;
      end
      S_MAC: begin
        cmd_o.mac = 1'b1;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(5)) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        cnt_d   = '0;
        state_d = status_i.face_zero ? S_IDLE : S_ACC_RD;
      end
      S_ACC_RD: begin
        cmd_o.acc_rd = 1'b1;
        cmd_o.sel    = cnt_q[1:0];
        state_d = S_ACC_WR;
      end
      S_ACC_WR: begin
        cmd_o.acc_add = 1'b1;
        cmd_o.sel     = cnt_q[1:0];
        cnt_d = cnt_q + CntW'(1);
        state_d = (cnt_q == CntW'(2)) ? S_IDLE : S_ACC_RD;
      end
      S_Q_RD: begin
        cmd_o.q_rd = 1'b1;
        state_d = S_Q_LAT;
      end
      S_Q_LAT: begin
        cmd_o.q_lat = 1'b1;
        state_d = S_Q_CHK;
      end
      S_Q_CHK: begin
        state_d = status_i.acc_zero ? S_OUT : S_SHIFT;
      end
      S_SHIFT: begin
        cnt_d = '0;
        if (status_i.need_shift) begin
          cmd_o.shift = 1'b1;
        end else begin
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.sq = 1'b1;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(2)) begin
          cnt_d   = '0;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt = 1'b1;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(31)) begin
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(47)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign clr_addr_o = clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
    end
  end

endmodule

### src/svn_dp.sv
// Datapath of the smooth vertex normals unit: memories, cross product, normalizer.
module svn_dp #(
  parameter int unsigned MAX_VERTICES = svn_pkg::MaxVerticesDef,
  parameter int unsigned ACC_BITS     = svn_pkg::AccBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  svn_pkg::svn_cmd_t               cmd_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] clr_addr_i,
  output svn_pkg::svn_status_t            status_o,
  input  logic [svn_pkg::InW-1:0]         in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [svn_pkg::OutW-1:0]        out_data_o
);
  import svn_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned NW = 36;

  // Input field decode.
  logic [1:0]      in_act;
  logic [IdxW-1:0] in_idx [3];
  logic [16:0]     in_ext [3];
  logic            in_ok  [3];
  assign in_act    = in_data_i[1:0];
  assign in_idx[0] = in_data_i[11:2];
  assign in_idx[1] = in_data_i[21:12];
  assign in_idx[2] = in_data_i[31:22];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_ext[k] = {7'd0, in_idx[k]};
      in_ok[k]  = in_ext[k] < 17'(MAX_VERTICES);
    end
  end

  logic [AW-1:0]   addr_q [3];
  logic [IdxW-1:0] vidx_q;
  logic            degen_q;

  // Position memory, {z, y, x}.
  logic [3*PosW-1:0] pos_rdata;
  svn_ram #(.WIDTH(3*PosW), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store_wr),
    .waddr_i (in_ext[0][AW-1:0]),
    .wdata_i (in_data_i[79:32]),
    .raddr_i (addr_q[cmd_i.sel]),
    .rdata_o (pos_rdata)
  );

  // Accumulator memory, {z, y, x}.
  logic [3*ACC_BITS-1:0] acc_rdata, acc_wdata;
  logic [AW-1:0]         acc_waddr;
  logic                  acc_we;
  svn_ram #(.WIDTH(3*ACC_BITS), .DEPTH(MAX_VERTICES)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (addr_q[cmd_i.sel]),
    .rdata_o (acc_rdata)
  );

  logic signed [PosW-1:0]     p_q [3][3];
  logic signed [PosW:0]       u_q [3], v_q [3];
  logic signed [NW-1:0]       n_q [3];
  logic [ACC_BITS-1:0]        mag_q [3];
  logic                       neg_q [3];
  logic                       zero_q;
  logic [61:0]                ssq_q;
  logic [63:0]                rem_q, root_q, bit_q;
  logic [45:0]                drem_q;
  logic [15:0]                quo_q;
  logic [15:0]                qv_q [3];

  // Cross product, one multiply a cycle.
  logic signed [PosW:0]   ma, mb;
  logic signed [2*PosW+1:0] prod;
  logic [1:0]             mac_k;
  always_comb begin
    case (cmd_i.cnt[2:0])
      3'd0:    begin ma = u_q[1]; mb = v_q[2]; end
      3'd1:    begin ma = u_q[2]; mb = v_q[1]; end
      3'd2:    begin ma = u_q[2]; mb = v_q[0]; end
      3'd3:    begin ma = u_q[0]; mb = v_q[2]; end
      3'd4:    begin ma = u_q[0]; mb = v_q[1]; end
      default: begin ma = u_q[1]; mb = v_q[0]; end
    endcase
    prod  = ma * mb;
    mac_k = cmd_i.cnt[2:1];
  end

  // Saturating accumulate and query magnitudes.
  logic signed [ACC_BITS-1:0] acc_old [3];
  logic signed [ACC_BITS:0]   acc_sum [3];
  logic [ACC_BITS-1:0]        acc_new [3];
  logic [ACC_BITS-1:0]        acc_mag [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_old[k] = acc_rdata[k*ACC_BITS +: ACC_BITS];
      acc_sum[k] = {acc_old[k][ACC_BITS-1], acc_old[k]}
                 + {{(ACC_BITS+1-NW){n_q[k][NW-1]}}, n_q[k]};
      if (acc_sum[k][ACC_BITS] != acc_sum[k][ACC_BITS-1]) begin
        acc_new[k] = acc_sum[k][ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                          : {1'b0, {(ACC_BITS-1){1'b1}}};
      end else begin
        acc_new[k] = acc_sum[k][ACC_BITS-1:0];
      end
      acc_mag[k] = acc_old[k][ACC_BITS-1] ? (~acc_old[k] + ACC_BITS'(1)) : acc_old[k];
    end
  end

  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = addr_q[cmd_i.sel];
    acc_wdata = '0;
    if (cmd_i.clr_wr) begin
      acc_we    = 1'b1;
      acc_waddr = clr_addr_i;
    end else if (cmd_i.q_lat) begin
      acc_we    = 1'b1;
      acc_waddr = addr_q[0];
    end else if (cmd_i.acc_add) begin
      acc_we    = 1'b1;
      acc_wdata = {acc_new[2], acc_new[1], acc_new[0]};
    end
  end

  // Sum of squares, square root and division step logic.
  logic [29:0] sq_op;
  logic [59:0] sq;
  logic [63:0] s_n, s_root, s_bit, s_trial;
  logic [1:0]  dcomp;
  logic [3:0]  dbit;
  logic [32:0] dden;
  logic [45:0] dnum, d_src;
  logic [48:0] d_trial;
  logic [15:0] q_src, q_new;
  logic [45:0] d_next;
  always_comb begin
    sq_op   = mag_q[cmd_i.cnt[1:0]][29:0];
    sq      = sq_op * sq_op;
    s_n     = (cmd_i.cnt == '0) ? {2'b00, ssq_q} : rem_q;
    s_root  = (cmd_i.cnt == '0) ? 64'd0 : root_q;
    s_bit   = (cmd_i.cnt == '0) ? 64'h4000_0000_0000_0000 : bit_q;
    s_trial = s_root + s_bit;
    dcomp   = cmd_i.cnt[5:4];
    dbit    = 4'd15 - cmd_i.cnt[3:0];
    dden    = {root_q[31:0], 1'b0};
    dnum    = {1'b0, mag_q[dcomp][29:0], 15'd0} + {14'd0, root_q[31:0]};
    d_src   = (dbit == 4'd15) ? dnum : drem_q;
    q_src   = (dbit == 4'd15) ? 16'd0 : quo_q;
    d_trial = {16'd0, dden} << dbit;
    if ({3'd0, d_src} >= d_trial) begin
      d_next = d_src - d_trial[45:0];
      q_new  = q_src | (16'd1 << dbit);
    end else begin
      d_next = d_src;
      q_new  = q_src;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      for (int k = 0; k < 3; k++) begin
        addr_q[k] <= in_ext[k][AW-1:0];
      end
      vidx_q  <= in_idx[0];
      degen_q <= 1'b1;
    end
    if (cmd_i.pos_lat) begin
      for (int c = 0; c < 3; c++) begin
        p_q[cmd_i.lat_sel][c] <= pos_rdata[c*PosW +: PosW];
      end
    end
    if (cmd_i.diff) begin
      for (int c = 0; c < 3; c++) begin
        u_q[c] <= {p_q[1][c][PosW-1], p_q[1][c]} - {p_q[0][c][PosW-1], p_q[0][c]};
        v_q[c] <= {p_q[2][c][PosW-1], p_q[2][c]} - {p_q[0][c][PosW-1], p_q[0][c]};
      end
    end
    if (cmd_i.mac) begin
      if (cmd_i.cnt[0]) begin
        n_q[mac_k] <= n_q[mac_k] - {{(NW-2*PosW-2){prod[2*PosW+1]}}, prod};
      end else begin
        n_q[mac_k] <= {{(NW-2*PosW-2){prod[2*PosW+1]}}, prod};
      end
    end
    if (cmd_i.q_lat) begin
      for (int k = 0; k < 3; k++) begin
        mag_q[k] <= acc_mag[k];
        neg_q[k] <= acc_old[k][ACC_BITS-1];
      end
      zero_q  <= (acc_rdata == '0);
      degen_q <= (acc_rdata == '0);
    end
    if (cmd_i.shift) begin
      for (int k = 0; k < 3; k++) begin
        mag_q[k] <= mag_q[k] >> 1;
      end
    end
    if (cmd_i.sq) begin
      ssq_q <= ((cmd_i.cnt == '0) ? 62'd0 : ssq_q) + {2'b00, sq};
    end
    if (cmd_i.sqrt) begin
      if (s_n >= s_trial) begin
        rem_q  <= s_n - s_trial;
        root_q <= (s_root >> 1) + s_bit;
      end else begin
        rem_q  <= s_n;
        root_q <= s_root >> 1;
      end
      bit_q <= s_bit >> 2;
    end
    if (cmd_i.div) begin
      drem_q <= d_next;
      quo_q  <= q_new;
      if (dbit == 4'd0) begin
        qv_q[dcomp] <= (q_new > ONE_Q14) ? ONE_Q14 : q_new;
      end
    end
  end

  // Result register.
  logic            ovalid_q;
  logic [OutW-1:0] odata_q;
  logic [NrmW-1:0] res [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      res[k] = neg_q[k] ? (~qv_q[k] + NrmW'(1)) : qv_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (degen_q) begin
        odata_q <= {5'd0, 1'b1, 16'd0, ONE_Q14, 16'd0, vidx_q};
      end else begin
        odata_q <= {5'd0, 1'b0, res[2], res[1], res[0], vidx_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  always_comb begin
    status_o.action     = in_act;
    status_o.a_ok       = in_ok[0];
    status_o.tri_ok     = in_ok[0] && in_ok[1] && in_ok[2];
    status_o.face_zero  = (n_q[0] == '0) && (n_q[1] == '0) && (n_q[2] == '0);
    status_o.acc_zero   = zero_q;
    status_o.need_shift = (mag_q[0][ACC_BITS-1:30] != '0) || (mag_q[1][ACC_BITS-1:30] != '0)
                       || (mag_q[2][ACC_BITS-1:30] != '0);
    status_o.out_free   = !ovalid_q || out_ready_i;
  end

endmodule

### src/smooth_vertex_normals_unit.sv
// Top level of the smooth vertex normals unit; one word is worked on at a time.
// A store writes the position of an index within the table; a triangle takes three position
// reads, six steps of one shared multiplier and, unless the face is zero, three accumulator
// read-modify-writes. A query takes up to 18 normalizing shifts, three squares, 32 root and 48
// divide steps, skipped for a zero sum or an index beyond the table; a stalled result holds the next word.
// After reset a pass over every entry zeroes the accumulators before any word is accepted.
module smooth_vertex_normals_unit #(
  parameter int unsigned MAX_VERTICES = svn_pkg::MaxVerticesDef,
  parameter int unsigned ACC_BITS     = svn_pkg::AccBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // action[1:0], index_a[11:2], index_b[21:12], index_c[31:22],
  // pos_x[47:32], pos_y[63:48], pos_z[79:64]
  input  logic [svn_pkg::InW-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // vert_idx[9:0], normal_x[25:10], normal_y[41:26], normal_z[57:42],
  // degenerate[58], zero fill above
  output logic [svn_pkg::OutW-1:0] m_axis_tdata_o
);
  import svn_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VERTICES);

  // The controller sequences each word; the datapath holds memories and arithmetic.
  svn_cmd_t    cmd;
  svn_status_t status;
  logic [AW-1:0] clr_addr;

  svn_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .clr_addr_o (clr_addr)
  );

  svn_dp #(.MAX_VERTICES(MAX_VERTICES), .ACC_BITS(ACC_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .clr_addr_i  (clr_addr),
    .status_o    (status),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

`ifndef NO_ASSERTIONS
  // No word is taken while the accumulator memory is still being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.clr_wr && s_axis_tready_o)) else $error("input accepted during clear");

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result overwritten");

  // Only one source drives the accumulator write port at a time.
  a_acc_write_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr_wr, cmd.acc_add, cmd.q_lat})) else $error("accumulator write clash");
`endif

endmodule
